@@ hdl/sc2d_pkg.sv @@
// shared constants, register codes and tap helper for the strided 2d convolution
// no dependencies
package sc2d_pkg;

    localparam int KR_DEF    = 3;
    localparam int KC_DEF    = 3;
    localparam int MAXW_DEF  = 1024;
    localparam int MAXH_DEF  = 1024;
    localparam int RES_DEPTH = 8;

    typedef enum logic [2:0] {
        REG_COLS   = 3'd0,
        REG_ROWS   = 3'd1,
        REG_STEP   = 3'd2,
        REG_BORDER = 3'd3,
        REG_COEF0  = 3'd4,
        REG_COEF1  = 3'd5,
        REG_COEF2  = 3'd6
    } t_reg;

    // tap n of a packed kernel row, zero beyond the third column
    function automatic logic signed [15:0] f_tap(input logic [47:0] row, input int n);
        logic signed [15:0] v;
        v = '0;
        if (n < 3) begin
            v = $signed(row[16*n +: 16]);
        end
        return v;
    endfunction

endpackage

@@ hdl/sc2d_if.sv @@
// pixel and result channel interfaces with valid/ready handshake
// no dependencies
interface sc2d_pix_if;
    logic       valid;
    logic       ready;
    logic [7:0] pixel_value;
    logic       drain;
    modport source (output valid, pixel_value, drain, input ready);
    modport sink (input valid, pixel_value, drain, output ready);
endinterface

interface sc2d_res_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] sum_out;
    logic               run_end;
    logic               frame_end;
    modport source (output valid, sum_out, run_end, frame_end, input ready);
    modport sink (input valid, sum_out, run_end, frame_end, output ready);
endinterface

@@ hdl/strided_2d_convolution.sv @@
// strided 2d correlation, line store in one column-wide memory, window and mac pipeline
// depends on sc2d_pkg and sc2d_if
// path: each result passes the s1 register, window, products, row sums, total and queue
// throughput: one pixel word per cycle while ready is high; ready drops for a right
// border output, a drain word's KERNEL_COLS line store reads and low queue credit
// reset: synchronous active low, registers to defaults, frame restarts, queue empties
// the line store is not cleared; it is only read at rows of the frame already written
module strided_2d_convolution
    import sc2d_pkg::*;
#(
    parameter int KERNEL_ROWS = KR_DEF,
    parameter int KERNEL_COLS = KC_DEF,
    parameter int MAX_WIDTH   = MAXW_DEF,
    parameter int MAX_HEIGHT  = MAXH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    sc2d_pix_if.sink    i_pix,
    sc2d_res_if.source  o_res,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);

    localparam int MAXD = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
    localparam int GW0  = $clog2(MAXD + 32) + 1;
    localparam int GW   = (GW0 < 12) ? 12 : GW0;
    localparam int AW   = $clog2(MAX_WIDTH);
    localparam int SW   = (KERNEL_ROWS > 1) ? $clog2(KERNEL_ROWS) : 1;
    localparam int JW   = 3;
    localparam int CW   = $clog2(RES_DEPTH + 1);
    localparam int QW   = $clog2(RES_DEPTH);
    localparam int EW   = KERNEL_ROWS * 8;

    typedef struct packed {
        logic                   valid;
        logic                   rd;
        logic                   wr;
        logic [AW-1:0]          addr;
        logic [7:0]             pix;
        logic [SW-1:0]          slot;
        logic [KERNEL_ROWS-1:0] mask;
        logic                   zero;
        logic                   clear;
        logic                   emit;
        logic                   run_end;
        logic                   frame_end;
    } t_evt;

    // configuration
    logic [10:0] r_cols, r_rows;
    logic [3:0]  r_step;
    logic        r_border;
    logic [47:0] r_coef [3];
    logic        cfg_wr, cfg_geo;
    t_reg        cfg_idx;

    assign cfg_wr  = psel & penable & pwrite;
    assign cfg_idx = t_reg'(paddr[5:3]);
    assign cfg_geo = cfg_wr & (cfg_idx == REG_COLS || cfg_idx == REG_ROWS ||
                               cfg_idx == REG_STEP || cfg_idx == REG_BORDER);
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cols    <= 11'd1;
            r_rows    <= 11'd1;
            r_step    <= 4'd1;
            r_border  <= 1'b0;
            r_coef[0] <= '0;
            r_coef[1] <= '0;
            r_coef[2] <= '0;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_COLS:   r_cols    <= pwdata[10:0];
                REG_ROWS:   r_rows    <= pwdata[10:0];
                REG_STEP:   r_step    <= pwdata[3:0];
                REG_BORDER: r_border  <= pwdata[0];
                REG_COEF0:  r_coef[0] <= pwdata[47:0];
                REG_COEF1:  r_coef[1] <= pwdata[47:0];
                REG_COEF2:  r_coef[2] <= pwdata[47:0];
                default:    ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_COLS:   prdata = {53'd0, r_cols};
            REG_ROWS:   prdata = {53'd0, r_rows};
            REG_STEP:   prdata = {60'd0, r_step};
            REG_BORDER: prdata = {63'd0, r_border};
            REG_COEF0:  prdata = {16'd0, r_coef[0]};
            REG_COEF1:  prdata = {16'd0, r_coef[1]};
            REG_COEF2:  prdata = {16'd0, r_coef[2]};
            default:    prdata = '0;
        endcase
    end

    // effective geometry
    logic [GW-1:0] w_w, w_h, w_s, w_b;
    logic [3:0]    w_rinit, w_cinit, w_sm1;

    always_comb begin
        w_w = (r_cols == 11'd0) ? GW'(1) :
              ((GW'(r_cols) > GW'(MAX_WIDTH)) ? GW'(MAX_WIDTH) : GW'(r_cols));
        w_h = (r_rows == 11'd0) ? GW'(1) :
              ((GW'(r_rows) > GW'(MAX_HEIGHT)) ? GW'(MAX_HEIGHT) : GW'(r_rows));
        w_s   = (r_step == 4'd0) ? GW'(1) : GW'(r_step);
        w_b   = GW'(r_border);
        w_sm1 = w_s[3:0] - 4'd1;
        if (r_border) begin
            w_rinit = (KERNEL_ROWS >= 2) ? 4'(KERNEL_ROWS - 2) : w_sm1;
            w_cinit = (KERNEL_COLS >= 2) ? 4'(KERNEL_COLS - 2) : w_sm1;
        end else begin
            w_rinit = 4'(KERNEL_ROWS - 1);
            w_cinit = 4'(KERNEL_COLS - 1);
        end
    end

    // frame position and sequencing
    logic          r_fresh, n_fresh, r_drn, n_drn, r_xpend, n_xpend, r_xfe, n_xfe;
    logic [GW-1:0] r_row, n_row, r_col, n_col, r_dcol, n_dcol;
    logic [SW-1:0] r_slot, n_slot;
    logic [3:0]    r_rwait, n_rwait, r_cwait, n_cwait;
    logic [JW-1:0] r_dstep, n_dstep;
    logic [CW-1:0] r_used, r_cnt;
    t_evt          s0, r_s1;

    logic in_acc, pix_acc, drn_acc, dact, pop;
    logic start;
    logic [GW-1:0] e_r, e_c, pc;
    logic [SW-1:0] e_slot, slot_nx;
    logic [3:0]    e_rw, e_cw, rw_nx, cw_nx;
    logic          rc, lastc, lastr, extra, fe_row, bottom, dlast, dfe;
    logic [JW-1:0] dj;

    assign dact    = (r_dstep != '0);
    assign i_pix.ready = !r_xpend && !dact && (r_used <= CW'(RES_DEPTH - 2));
    assign in_acc  = i_pix.valid & i_pix.ready;
    assign pix_acc = in_acc & !i_pix.drain;
    assign drn_acc = in_acc & i_pix.drain & r_drn;
    assign pop     = o_res.valid & o_res.ready;
    assign start   = r_fresh | r_drn;

    always_comb begin
        e_r    = start ? '0 : r_row;
        e_c    = start ? '0 : r_col;
        e_slot = start ? '0 : r_slot;
        e_rw   = start ? w_rinit : r_rwait;
        e_cw   = start ? w_cinit : r_cwait;
        rw_nx  = (e_rw == 4'd0) ? w_sm1 : e_rw - 4'd1;
        cw_nx  = (e_cw == 4'd0) ? w_sm1 : e_cw - 4'd1;
        slot_nx = (e_slot == SW'(KERNEL_ROWS - 1)) ? '0 : e_slot + SW'(1);
        rc     = (e_rw == 4'd0);
        lastc  = (e_c == w_w - GW'(1));
        lastr  = (e_r == w_h - GW'(1));
        extra  = r_border & lastc & rc & (cw_nx == 4'd0);
        fe_row = (e_r + w_b + w_s) >= (w_h + (w_b << 1));
        bottom = lastc & lastr & r_border & (rw_nx == 4'd0) &
                 ((w_w + GW'(2)) >= GW'(KERNEL_COLS));
        dj     = drn_acc ? '0 : r_dstep;
        pc     = r_dcol - GW'(KERNEL_COLS - 1) + GW'(dj);
        dlast  = (dj == JW'(KERNEL_COLS - 1));
        dfe    = (r_dcol + w_s) >= (w_w + GW'(2));

        n_fresh = r_fresh;
        n_drn   = r_drn;
        n_xpend = r_xpend;
        n_xfe   = r_xfe;
        n_row   = r_row;
        n_col   = r_col;
        n_dcol  = r_dcol;
        n_slot  = r_slot;
        n_rwait = r_rwait;
        n_cwait = r_cwait;
        n_dstep = r_dstep;
        s0      = '0;

        if (cfg_geo) begin
            n_fresh = 1'b1;
            n_drn   = 1'b0;
            n_xpend = 1'b0;
            n_dstep = '0;
        end else if (pix_acc) begin
            s0.valid     = 1'b1;
            s0.rd        = 1'b1;
            s0.wr        = 1'b1;
            s0.addr      = e_c[AW-1:0];
            s0.pix       = i_pix.pixel_value;
            s0.slot      = e_slot;
            for (int k = 0; k < KERNEL_ROWS; k++) begin
                s0.mask[k] = (e_r >= GW'(k));
            end
            s0.clear     = (e_c == '0);
            s0.emit      = rc & (e_cw == 4'd0);
            s0.run_end   = s0.emit & !extra;
            s0.frame_end = fe_row & ((e_c + w_b + w_s) >= (w_w + (w_b << 1)));
            n_xpend = extra;
            n_xfe   = fe_row;
            n_fresh = 1'b0;
            n_drn   = 1'b0;
            if (lastc) begin
                n_col   = '0;
                n_cwait = w_cinit;
                n_slot  = slot_nx;
                n_rwait = rw_nx;
                n_row   = e_r + GW'(1);
                if (lastr) begin
                    if (bottom) begin
                        n_drn  = 1'b1;
                        n_dcol = GW'(KERNEL_COLS - 1);
                    end else begin
                        n_fresh = 1'b1;
                    end
                end
            end else begin
                n_col   = e_c + GW'(1);
                n_cwait = cw_nx;
                n_row   = e_r;
                n_slot  = e_slot;
                n_rwait = e_rw;
            end
        end else if (r_xpend) begin
            s0.valid     = 1'b1;
            s0.zero      = 1'b1;
            s0.emit      = 1'b1;
            s0.run_end   = 1'b1;
            s0.frame_end = r_xfe;
            n_xpend = 1'b0;
        end else if (drn_acc | dact) begin
            s0.valid = 1'b1;
            s0.rd    = 1'b1;
            s0.addr  = AW'(pc - GW'(1));
            s0.slot  = r_slot;
            for (int k = 0; k < KERNEL_ROWS; k++) begin
                s0.mask[k] = (r_row >= GW'(k));
            end
            s0.zero      = (pc == '0) || (pc > w_w);
            s0.emit      = dlast;
            s0.run_end   = dlast;
            s0.frame_end = dlast & dfe;
            n_dstep = dlast ? '0 : dj + JW'(1);
            if (dlast) begin
                if (dfe) begin
                    n_fresh = 1'b1;
                    n_drn   = 1'b0;
                end else begin
                    n_dcol = r_dcol + w_s;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fresh <= 1'b1;
            r_drn   <= 1'b0;
            r_xpend <= 1'b0;
            r_dstep <= '0;
            r_used  <= '0;
            r_s1    <= '0;
        end else begin
            r_fresh <= n_fresh;
            r_drn   <= n_drn;
            r_xpend <= n_xpend;
            r_dstep <= n_dstep;
            r_used  <= r_used + CW'(s0.emit) - CW'(pop);
            r_s1    <= s0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_xfe   <= n_xfe;
        r_row   <= n_row;
        r_col   <= n_col;
        r_dcol  <= n_dcol;
        r_slot  <= n_slot;
        r_rwait <= n_rwait;
        r_cwait <= n_cwait;
    end

    // line store, one entry per column holding one byte per kept row
    logic [EW-1:0] mem [MAX_WIDTH];
    logic [EW-1:0] r_q, r_fwdd, ent, wdata;
    logic          r_fwd, s1_wr;

    assign s1_wr = r_s1.valid & r_s1.wr;

    always_ff @(posedge i_clk) begin
        if (s0.valid & s0.rd) begin
            r_q <= mem[s0.addr];
        end
        if (s1_wr) begin
            mem[r_s1.addr] <= wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd <= 1'b0;
        end else begin
            r_fwd <= s0.valid & s0.rd & s1_wr & (r_s1.addr == s0.addr);
        end
    end

    always_ff @(posedge i_clk) begin
        r_fwdd <= wdata;
    end

    // column build, write back and window shift
    logic [7:0] col [KERNEL_ROWS];
    logic [7:0] r_win [KERNEL_ROWS][KERNEL_COLS];
    int         sk;

    always_comb begin
        ent   = r_fwd ? r_fwdd : r_q;
        wdata = ent;
        wdata[8*r_s1.slot +: 8] = r_s1.pix;
        for (int k = 0; k < KERNEL_ROWS; k++) begin
            sk = int'(r_s1.slot) + KERNEL_ROWS - k;
            if (sk >= KERNEL_ROWS) begin
                sk = sk - KERNEL_ROWS;
            end
            if (r_s1.zero) begin
                col[KERNEL_ROWS-1-k] = '0;
            end else if (k == 0) begin
                col[KERNEL_ROWS-1-k] = r_s1.wr ? r_s1.pix : 8'd0;
            end else begin
                col[KERNEL_ROWS-1-k] = r_s1.mask[k] ? ent[8*sk +: 8] : 8'd0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s1.valid) begin
            for (int m = 0; m < KERNEL_ROWS; m++) begin
                for (int n = 0; n < KERNEL_COLS - 1; n++) begin
                    r_win[m][n] <= r_s1.clear ? 8'd0 : r_win[m][n+1];
                end
                r_win[m][KERNEL_COLS-1] <= col[m];
            end
        end
    end

    // multiply, row sums, total
    logic               r_s2v, r_s3v, r_s4v, r_s5v;
    logic [1:0]         r_s2f, r_s3f, r_s4f, r_s5f;
    logic signed [24:0] r_prod [KERNEL_ROWS][KERNEL_COLS];
    logic signed [31:0] r_rsum [KERNEL_ROWS];
    logic signed [31:0] r_sum, rs_nx [KERNEL_ROWS], tot_nx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2v <= 1'b0;
            r_s3v <= 1'b0;
            r_s4v <= 1'b0;
            r_s5v <= 1'b0;
        end else begin
            r_s2v <= r_s1.valid & r_s1.emit;
            r_s3v <= r_s2v;
            r_s4v <= r_s3v;
            r_s5v <= r_s4v;
        end
    end

    always_comb begin
        for (int m = 0; m < KERNEL_ROWS; m++) begin
            rs_nx[m] = '0;
            for (int n = 0; n < KERNEL_COLS; n++) begin
                rs_nx[m] = rs_nx[m] + 32'(r_prod[m][n]);
            end
        end
        tot_nx = '0;
        for (int m = 0; m < KERNEL_ROWS; m++) begin
            tot_nx = tot_nx + r_rsum[m];
        end
    end

    always_ff @(posedge i_clk) begin
        r_s2f <= {r_s1.run_end, r_s1.frame_end};
        r_s3f <= r_s2f;
        r_s4f <= r_s3f;
        r_s5f <= r_s4f;
        for (int m = 0; m < KERNEL_ROWS; m++) begin
            for (int n = 0; n < KERNEL_COLS; n++) begin
                r_prod[m][n] <= $signed({1'b0, r_win[m][n]}) * f_tap(r_coef[m], n);
            end
            r_rsum[m] <= rs_nx[m];
        end
        r_sum <= tot_nx;
    end

    // result queue
    logic [33:0]   r_fifo [RES_DEPTH];
    logic [QW-1:0] r_wp, r_rp;

    always_ff @(posedge i_clk) begin
        if (r_s5v) begin
            r_fifo[r_wp] <= {r_sum, r_s5f};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (r_s5v) begin
                r_wp <= (r_wp == QW'(RES_DEPTH - 1)) ? '0 : r_wp + QW'(1);
            end
            if (pop) begin
                r_rp <= (r_rp == QW'(RES_DEPTH - 1)) ? '0 : r_rp + QW'(1);
            end
            r_cnt <= r_cnt + CW'(r_s5v) - CW'(pop);
        end
    end

    assign o_res.valid     = (r_cnt != '0);
    assign o_res.sum_out   = $signed(r_fifo[r_rp][33:2]);
    assign o_res.run_end   = r_fifo[r_rp][1];
    assign o_res.frame_end = r_fifo[r_rp][0];

    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= CW'(RES_DEPTH))
        else $error("result credit overflow");

    a_queue_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s5v |-> (r_cnt < CW'(RES_DEPTH)) || pop)
        else $error("push into full result queue");

    a_queue_credit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= r_used)
        else $error("queued words exceed issued results");

    a_extra_after_pix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_xpend) |-> $past(pix_acc))
        else $error("border output without a row end pixel");

endmodule
